// ===== rtl/core/gss3_pkg.sv =====
// package for the 3x3 gauss-seidel solver core
// word types, register indexes and status codes; no dependencies
package gss3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TOL_W     = 17;
    localparam int ITER_W    = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'd1;

    typedef enum logic [1:0] {
        ST_CONVERGED  = 2'd0,
        ST_ITER_LIMIT = 2'd1,
        ST_ZERO_DIAG  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a02;
        logic signed [31:0] a10;
        logic signed [31:0] a11;
        logic signed [31:0] a12;
        logic signed [31:0] a20;
        logic signed [31:0] a21;
        logic signed [31:0] a22;
        logic signed [31:0] rhs0;
        logic signed [31:0] rhs1;
        logic signed [31:0] rhs2;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] sol0;
        logic signed [31:0] sol1;
        logic signed [31:0] sol2;
        logic [ITER_W-1:0]  sweeps_done;
        logic [1:0]         status;
    } out_word_t;

endpackage

// ===== rtl/core/gauss_seidel_solver_3x3_core.sv =====
// top level of the 3x3 gauss-seidel solver core
// depends on gss3_pkg
//
// Solves one 3x3 system A*x = rhs per input word in signed Q16.16, starting
// from zero estimates and running Gauss-Seidel sweeps until the largest change
// in a sweep is at or below tolerance or max_iterations sweeps have run. One
// shared 32x32 multiplier and one shared restoring divider (one quotient bit
// per cycle over a 64-bit magnitude) do all arithmetic under a small sequencer.
// Each update of one unknown runs through the multiply states S_MUL_A and
// S_MUL_B, the combine state, the divider setup state, the divide steps and
// the finish state; a sweep is three updates followed by the check state.
// The result word of an item with a zero diagonal is presented in the cycle
// after acceptance; the next word can be accepted only after the result word
// has been taken by the output side. The block holds in_stall high from
// acceptance until its result word has been taken by the output side.
// Configuration writes are always ready and should be made only while the
// block is idle.
module gauss_seidel_solver_3x3_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  gss3_pkg::in_word_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output gss3_pkg::out_word_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gss3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gss3_pkg::CFG_DAT_W-1:0] cfg_data
);
    import gss3_pkg::*;

    localparam int DIV_STEPS = 64;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL_A, S_MUL_B, S_COMB, S_DIV_SET, S_DIV, S_DIV_END, S_CHECK
    } state_t;

    state_t state_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [ITER_W-1:0] max_iter_reg;
    logic [ITER_W-1:0] sweeps_reg;
    logic [1:0]        row_reg;
    logic              busy_reg;
    logic              out_valid_reg;
    out_word_t         out_reg;

    logic signed [31:0] a_reg [9];
    logic signed [31:0] r_reg [3];
    logic signed [31:0] x_reg [3];
    logic signed [31:0] p_reg [3];

    // shared multiplier product registers
    logic signed [63:0] prod_a_reg, prod_b_reg;
    // shared divider
    logic [63:0]       dnum_reg;   // dividend shifting out, quotient shifting in
    logic [64:0]       drem_reg;
    logic [31:0]       dden_reg;
    logic              dneg_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [31:0]       big_reg;

    // column selection for the current row
    logic signed [31:0] ca, cb, xa, xb, diag, rhs;
    always_comb
    begin
        unique case (row_reg)
            2'd0:
            begin
                ca = a_reg[1]; xa = x_reg[1]; cb = a_reg[2]; xb = x_reg[2];
                diag = a_reg[0]; rhs = r_reg[0];
            end
            2'd1:
            begin
                ca = a_reg[3]; xa = x_reg[0]; cb = a_reg[5]; xb = x_reg[2];
                diag = a_reg[4]; rhs = r_reg[1];
            end
            default:
            begin
                ca = a_reg[6]; xa = x_reg[0]; cb = a_reg[7]; xb = x_reg[1];
                diag = a_reg[8]; rhs = r_reg[2];
            end
        endcase
    end

    // one multiplier, operands chosen by state
    logic signed [31:0] mul_x, mul_y;
    logic signed [63:0] mul_p;
    assign mul_x = (state_reg == S_MUL_A) ? ca : cb;
    assign mul_y = (state_reg == S_MUL_A) ? xa : xb;
    assign mul_p = mul_x * mul_y;

    // numerator: rhs*2^frac - pa, then clamped subtract of pb
    logic signed [63:0] num_1;
    logic signed [64:0] num_2;
    logic signed [63:0] num_c;
    assign num_1 = (64'(rhs) <<< FRAC_BITS) - prod_a_reg;
    assign num_2 = 65'(num_1) - 65'(prod_b_reg);
    always_comb
    begin
        if (num_2[64] != num_2[63])
            num_c = num_2[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            num_c = num_2[63:0];
    end

    // restoring division step
    logic [64:0] trial_rem;
    logic [65:0] trial_sub;
    assign trial_rem = {drem_reg[63:0], dnum_reg[63]};
    assign trial_sub = {1'b0, trial_rem} - {34'd0, dden_reg};

    // saturated signed quotient
    logic signed [31:0] q_sat;
    always_comb
    begin
        if (dneg_reg)
            q_sat = (dnum_reg > 64'h8000_0000) ? 32'sh8000_0000
                                               : 32'(-dnum_reg);
        else
            q_sat = (dnum_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                               : dnum_reg[31:0];
    end

    logic signed [32:0] delta;
    logic [31:0]        delta_abs;
    assign delta     = 33'(q_sat) - 33'(p_reg[row_reg]);
    assign delta_abs = delta[32] ? 32'(-delta) : delta[31:0];

    logic [ITER_W-1:0] limit;
    assign limit = (max_iter_reg == '0) ? ITER_W'(1) : max_iter_reg;

    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tol_reg       <= TOL_W'(1);
            max_iter_reg  <= ITER_W'(255);
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            sweeps_reg    <= '0;
            row_reg       <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_TOLERANCE)
                    tol_reg <= cfg_data[TOL_W-1:0];
                else if (cfg_index == REG_MAX_ITER)
                    max_iter_reg <= cfg_data[ITER_W-1:0];
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
                busy_reg      <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !busy_reg)
                    begin
                        busy_reg <= 1'b1;
                        a_reg[0] <= in_data.a00; a_reg[1] <= in_data.a01;
                        a_reg[2] <= in_data.a02; a_reg[3] <= in_data.a10;
                        a_reg[4] <= in_data.a11; a_reg[5] <= in_data.a12;
                        a_reg[6] <= in_data.a20; a_reg[7] <= in_data.a21;
                        a_reg[8] <= in_data.a22;
                        r_reg[0] <= in_data.rhs0; r_reg[1] <= in_data.rhs1;
                        r_reg[2] <= in_data.rhs2;
                        for (int i = 0; i < 3; i++)
                        begin
                            x_reg[i] <= '0;
                            p_reg[i] <= '0;
                        end
                        sweeps_reg <= '0;
                        row_reg    <= '0;
                        big_reg    <= '0;
                        if (in_data.a00 == 0 || in_data.a11 == 0 || in_data.a22 == 0)
                        begin
                            out_reg       <= '{32'sd0, 32'sd0, 32'sd0, '0, ST_ZERO_DIAG};
                            out_valid_reg <= 1'b1;
                        end
                        else
                            state_reg <= S_MUL_A;
                    end
                end
                S_MUL_A:
                begin
                    prod_a_reg <= mul_p;
                    state_reg  <= S_MUL_B;
                end
                S_MUL_B:
                begin
                    prod_b_reg <= mul_p;
                    state_reg  <= S_COMB;
                end
                S_COMB:
                begin
                    // magnitudes and sign of the quotient
                    dneg_reg  <= num_c[63] ^ diag[31];
                    dnum_reg  <= num_c[63] ? -num_c : num_c;
                    dden_reg  <= diag[31] ? -diag : diag;
                    state_reg <= S_DIV_SET;
                end
                S_DIV_SET:
                begin
                    drem_reg  <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!trial_sub[65])
                    begin
                        drem_reg <= trial_sub[64:0];
                        dnum_reg <= {dnum_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= trial_rem;
                        dnum_reg <= {dnum_reg[62:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                        state_reg <= S_DIV_END;
                end
                S_DIV_END:
                begin
                    x_reg[row_reg] <= q_sat;
                    if (delta_abs > big_reg)
                        big_reg <= delta_abs;
                    if (row_reg == 2'd2)
                    begin
                        row_reg    <= '0;
                        sweeps_reg <= sweeps_reg + 1'b1;
                        state_reg  <= S_CHECK;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= S_MUL_A;
                    end
                end
                S_CHECK:
                begin
                    if (big_reg <= 32'(tol_reg) || sweeps_reg >= limit)
                    begin
                        out_reg <= '{x_reg[0], x_reg[1], x_reg[2], sweeps_reg,
                                     (big_reg <= 32'(tol_reg)) ? ST_CONVERGED
                                                               : ST_ITER_LIMIT};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            p_reg[i] <= x_reg[i];
                        big_reg   <= '0;
                        state_reg <= S_MUL_A;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/gss3_checker.sv =====
// port-level checker for gauss_seidel_solver_3x3_core
// depends on gss3_pkg; bound to the top level below
module gss3_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input gss3_pkg::out_word_t out_data
);
    import gss3_pkg::*;

    // a result word is pending only while the block holds off input
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result pending while input open");

    // an accepted word closes the input in the next cycle
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not closed after accept");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    // zero diagonal status comes with no sweeps
    a_zero_diag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_ZERO_DIAG) |-> out_data.sweeps_done == '0)
        else $error("zero diagonal with sweeps");

    // any other status needs at least one sweep
    a_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_ZERO_DIAG) |-> out_data.sweeps_done != '0)
        else $error("result without a sweep");

endmodule

bind gauss_seidel_solver_3x3_core gss3_checker u_gss3_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== dv/tb_top.sv =====
// testbench for the 3x3 gauss-seidel solver core
// self-checking: directed table then random systems; depends on gss3_pkg
`timescale 1ns / 100ps

module tb_top;
    import gss3_pkg::*;

    localparam int  WDOG_LIMIT = 700000;
    localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SMIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    // directed row: one input word, and a hand-written answer where chk is set
    typedef struct {
        in_word_t  w;
        bit        chk;
        out_word_t ans;
    } dir_row_t;

    typedef struct {
        bit        chk;
        out_word_t ans;
    } hand_ans_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_word_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // shadow of the solver registers
    logic [TOL_W-1:0]  tol_sh;
    logic [ITER_W-1:0] iter_sh;

    out_word_t  solution_q[$];   // solutions still owed by the block
    hand_ans_t  hand_q[$];       // per sent word: typed answer, if any
    dir_row_t   dir_rows[$];

    int  mismatches;
    int  idle_cycles;
    int  burst_left;
    int  stall_mode;
    int  cyc;

    gauss_seidel_solver_3x3_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one estimate update: wide numerator, truncating divide, 32-bit saturation
    function automatic longint gs_update(longint rhs, longint ca, longint xa,
                                         longint cb, longint xb, longint diag);
        longint      num;
        longint      pb;
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        bit          neg;
        num = rhs * (64'sd1 <<< FRAC_BITS);
        num = num - ca * xa;
        pb  = cb * xb;
        // last subtraction clamps to the signed 64-bit range
        if (pb > 0 && num < SMIN + pb)
            num = SMIN;
        else if (pb < 0 && num > SMAX + pb)
            num = SMAX;
        else
            num = num - pb;
        neg = (num < 0) != (diag < 0);
        un  = (num < 0)  ? 64'd0 - 64'(num)  : 64'(num);
        ud  = (diag < 0) ? 64'd0 - 64'(diag) : 64'(diag);
        q   = un / ud;
        if (neg)
        begin
            if (q > 64'h8000_0000)
                return -64'sh8000_0000;
            return -longint'(q);
        end
        if (q > 64'h7FFF_FFFF)
            return 64'sh7FFF_FFFF;
        return longint'(q);
    endfunction

    function automatic longint absdiff(longint a, longint b);
        longint d;
        d = a - b;
        return (d < 0) ? -d : d;
    endfunction

    function automatic out_word_t solve_system(in_word_t w);
        out_word_t r;
        longint    a[3][3];
        longint    b[3];
        longint    x[3];
        longint    p[3];
        longint    big;
        int        limit;
        int        sweeps;
        status_t   st;
        a[0][0] = w.a00; a[0][1] = w.a01; a[0][2] = w.a02;
        a[1][0] = w.a10; a[1][1] = w.a11; a[1][2] = w.a12;
        a[2][0] = w.a20; a[2][1] = w.a21; a[2][2] = w.a22;
        b[0] = w.rhs0; b[1] = w.rhs1; b[2] = w.rhs2;
        x[0] = 0; x[1] = 0; x[2] = 0;
        limit  = (iter_sh == 0) ? 1 : int'(iter_sh);
        sweeps = 0;
        if (a[0][0] == 0 || a[1][1] == 0 || a[2][2] == 0)
            st = ST_ZERO_DIAG;
        else
        begin
            forever
            begin
                p = x;
                x[0] = gs_update(b[0], a[0][1], x[1], a[0][2], x[2], a[0][0]);
                x[1] = gs_update(b[1], a[1][0], x[0], a[1][2], x[2], a[1][1]);
                x[2] = gs_update(b[2], a[2][0], x[0], a[2][1], x[1], a[2][2]);
                sweeps++;
                big = absdiff(x[0], p[0]);
                if (absdiff(x[1], p[1]) > big)
                    big = absdiff(x[1], p[1]);
                if (absdiff(x[2], p[2]) > big)
                    big = absdiff(x[2], p[2]);
                // converged wins over the limit on the last sweep
                if (big <= longint'(tol_sh))
                begin
                    st = ST_CONVERGED;
                    break;
                end
                if (sweeps >= limit)
                begin
                    st = ST_ITER_LIMIT;
                    break;
                end
            end
        end
        r.sol0        = x[0][31:0];
        r.sol1        = x[1][31:0];
        r.sol2        = x[2][31:0];
        r.sweeps_done = sweeps[ITER_W-1:0];
        r.status      = st;
        return r;
    endfunction

    function automatic in_word_t identity_sys(logic [31:0] r0, logic [31:0] r1,
                                              logic [31:0] r2, logic [31:0] d);
        in_word_t w;
        w = '0;
        w.a00 = d; w.a11 = d; w.a22 = d;
        w.rhs0 = r0; w.rhs1 = r1; w.rhs2 = r2;
        return w;
    endfunction

    function automatic logic [31:0] srand_mag(int lo, int hi);
        logic [31:0] m;
        m = $urandom_range(hi, lo);
        return $urandom_range(1, 0) ? -m : m;
    endfunction

    // kind: 0 diagonally dominant, 1 full noise, 2 one diagonal forced to zero
    function automatic in_word_t random_sys(int kind);
        in_word_t w;
        if (kind == 1)
        begin
            w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return w;
        end
        w.a00 = srand_mag(65536, 262144);
        w.a11 = srand_mag(65536, 262144);
        w.a22 = srand_mag(65536, 262144);
        w.a01 = srand_mag(0, 16384); w.a02 = srand_mag(0, 16384);
        w.a10 = srand_mag(0, 16384); w.a12 = srand_mag(0, 16384);
        w.a20 = srand_mag(0, 16384); w.a21 = srand_mag(0, 16384);
        w.rhs0 = srand_mag(0, 1 << 20);
        w.rhs1 = srand_mag(0, 1 << 20);
        w.rhs2 = srand_mag(0, 1 << 20);
        if (kind == 2)
        begin
            case ($urandom_range(2, 0))
                0: w.a00 = '0;
                1: w.a11 = '0;
                default: w.a22 = '0;
            endcase
        end
        return w;
    endfunction

    function automatic out_word_t typed_ans(logic [31:0] s0, logic [31:0] s1,
                                            logic [31:0] s2, int sw, status_t st);
        out_word_t r;
        r.sol0 = s0; r.sol1 = s1; r.sol2 = s2;
        r.sweeps_done = sw[ITER_W-1:0];
        r.status = st;
        return r;
    endfunction

    // input side: bursts of words with random gaps between bursts
    task automatic send_word(in_word_t w, bit chk, out_word_t ans);
        hand_ans_t h;
        if (burst_left == 0)
        begin
            repeat ($urandom_range(20, 1)) @(posedge clk);
            burst_left = $urandom_range(8, 1);
        end
        h.chk = chk;
        h.ans = ans;
        hand_q.push_back(h);
        in_data  <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        // keep valid high inside a burst, the next word follows in this step
        if (burst_left == 0)
            in_valid <= 1'b0;
    endtask

    // wait until every owed solution has come, then let the block settle
    task automatic drain();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
        end
        while (solution_q.size() != 0 || hand_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] dat);
        cfg_index <= idx;
        cfg_data  <= dat;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // set both registers; unused upper data bits carry random junk
    task automatic set_regs(int tol, int iters);
        cfg_write(REG_TOLERANCE, ($urandom & ~32'h1FFFF) | tol[16:0]);
        cfg_write(REG_MAX_ITER, ($urandom & ~32'h3FF) | iters[9:0]);
    endtask

    // receiver stall pattern; a new style is drawn when the low bits of cyc are zero
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            cyc        <= 0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (cyc[5:0] == 6'd0)
                stall_mode <= $urandom_range(2, 0);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(2, 0) == 0);
                default: out_stall <= (cyc[2:0] < 3'd3);
            endcase
        end
    end

    // monitor: input acceptance, register writes and result checking
    always @(posedge clk)
    begin
        hand_ans_t h;
        out_word_t e;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TOLERANCE)
                    tol_sh <= cfg_data[TOL_W-1:0];
                else if (cfg_index == REG_MAX_ITER)
                    iter_sh <= cfg_data[ITER_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                h = hand_q.pop_front();
                solution_q.push_back(h.chk ? h.ans : solve_system(in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (solution_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", out_data);
                end
                else
                begin
                    e = solution_q.pop_front();
                    if (out_data.sol0 !== e.sol0 || out_data.sol1 !== e.sol1 ||
                        out_data.sol2 !== e.sol2 ||
                        out_data.sweeps_done !== e.sweeps_done ||
                        out_data.status !== e.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp sol %h %h %h sw %0d st %0d, got %h %h %h sw %0d st %0d",
                                     e.sol0, e.sol1, e.sol2, e.sweeps_done, e.status,
                                     out_data.sol0, out_data.sol1, out_data.sol2,
                                     out_data.sweeps_done, out_data.status);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        dir_row_t  row;
        out_word_t none;
        int        tols[6];
        int        iters[6];
        int        kind;
        int        k;
        none = '0;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        tol_sh     = 17'd1;
        iter_sh    = 10'd255;
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 0;

        // directed table, run at the reset register values
        row.w = '0; row.chk = 1;
        row.ans = typed_ans(0, 0, 0, 0, ST_ZERO_DIAG);
        dir_rows.push_back(row);
        row.w = identity_sys(32'h1234, 32'h5678, 32'h9ABC, 32'h10000);
        row.w.a00 = '0;
        dir_rows.push_back(row);
        row.w = identity_sys(32'h1234, 32'h5678, 32'h9ABC, 32'h10000);
        row.w.a11 = '0;
        dir_rows.push_back(row);
        row.w = identity_sys(32'h1234, 32'h5678, 32'h9ABC, 32'h10000);
        row.w.a22 = '0;
        dir_rows.push_back(row);
        // identity: exact in one sweep, zero change on the second
        row.w = identity_sys(32'h7FFFFFFF, 32'h80000000, 32'h12345, 32'h10000);
        row.ans = typed_ans(32'h7FFFFFFF, 32'h80000000, 32'h12345, 2, ST_CONVERGED);
        dir_rows.push_back(row);
        row.w = identity_sys(0, 0, 0, 32'h10000);
        row.ans = typed_ans(0, 0, 0, 1, ST_CONVERGED);
        dir_rows.push_back(row);
        // saturation corners and all-extreme fields go to the predictor
        row.chk = 0; row.ans = none;
        row.w = identity_sys(32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h1);
        dir_rows.push_back(row);
        row.w = identity_sys(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        dir_rows.push_back(row);
        row.w = identity_sys(32'h80000000, 32'h80000000, 32'h80000000, 32'hFFFF0000);
        dir_rows.push_back(row);
        row.w = identity_sys(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        dir_rows.push_back(row);
        row.w = '1;
        for (int i = 0; i < 12; i++)
            row.w[i*32 +: 32] = 32'h7FFFFFFF;
        dir_rows.push_back(row);
        for (int i = 0; i < 12; i++)
            row.w[i*32 +: 32] = 32'h80000000;
        dir_rows.push_back(row);
        for (int i = 0; i < 6; i++)
        begin
            row.w = random_sys(0);
            dir_rows.push_back(row);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].chk, dir_rows[i].ans);
        drain();

        // converging exactly on the last allowed sweep
        set_regs(1, 2);
        send_word(identity_sys(32'h4000, 32'hFFFF0000, 32'h7, 32'h10000), 1,
                  typed_ans(32'h4000, 32'hFFFF0000, 32'h7, 2, ST_CONVERGED));
        drain();

        // random phases: tolerance / iteration limit, extremes included
        tols  = '{1, 0, 65536, 32'h1FFFF, 300, 1};
        iters = '{6, 0, 4, 3, 1023, 8};
        for (int ph = 0; ph < 6; ph++)
        begin
            set_regs(tols[ph], iters[ph]);
            if (iters[ph] == 1023)
            begin
                // one system that runs the full limit of sweeps
                send_word(identity_sys(32'h100, 32'h200, 32'h300, 32'h10000) |
                          {32'h0, 32'h20000, 32'h0, 32'h20000, 32'h0, 32'h20000,
                           32'h0, 32'h20000, 32'h0, 96'h0}, 0, none);
                drain();
            end
            for (int n = 0; n < 83; n++)
            begin
                k = $urandom_range(9, 0);
                kind = (k < 7) ? 0 : (k < 9) ? 1 : 2;
                if (iters[ph] > 64 && kind == 1)
                    kind = 0;
                send_word(random_sys(kind), 0, none);
                // hold off now and then until the block has answered everything
                if (n == 40)
                    drain();
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
